// File: rtl/core/bsc_pkg.sv
// shared types, widths and constants of the b-spline curve subdivider
// no dependencies; imported by every module of the block

package bsc_pkg;

  localparam int DIVISIONS_DEF = 50;
  localparam int DIV_MIN       = 1;
  localparam int DIV_MAX       = 64;

  localparam int NPTS        = 4;   // control points in one window
  localparam int COORD_W     = 32;  // q16.16
  localparam int WEIGHT_W    = 17;  // unsigned q0.17, largest weight is 2/3
  localparam int WEIGHT_FRAC = 17;
  localparam int PROD_W      = COORD_W + WEIGHT_W + 1;
  localparam int TERM_W      = PROD_W - WEIGHT_FRAC;
  localparam int SUM_W       = TERM_W + 2;

  localparam logic [1:0] HELD_FULL = 2'd3;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [WEIGHT_W-1:0] weight_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef coord_t  [NPTS-1:0] coord_vec_t;
  typedef weight_t [NPTS-1:0] weight_vec_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // segments per window, held to the supported range
  function automatic int div_clamp(input int d);
    int r;
    r = d;
    if (r < DIV_MIN) r = DIV_MIN;
    if (r > DIV_MAX) r = DIV_MAX;
    return r;
  endfunction

endpackage

// File: rtl/core/bsc_weight_rom.sv
// constant table of q0.17 cubic b-spline basis weights, one row per t = j/divisions
// depends on bsc_pkg

module bsc_weight_rom
  import bsc_pkg::*;
#(
  parameter int DIVISIONS = DIVISIONS_DEF,
  localparam int DIV_C = div_clamp(DIVISIONS),
  localparam int EW    = $clog2(DIV_C + 1)
) (
  input  logic [EW-1:0] eval_idx,
  output weight_vec_t   weights
);

  localparam longint D      = DIV_C;
  localparam longint D3     = D * D * D;
  localparam longint DEN    = 6 * D3;
  localparam longint WSCALE = longint'(1) << WEIGHT_FRAC;

  weight_vec_t wtab [DIV_C+1];

  // round half up: (num * 2^17 + 3*d^3) / (6*d^3)
  for (genvar j = 0; j <= DIV_C; j++) begin : g_row
    localparam longint J    = j;
    localparam longint M    = D - J;
    localparam longint NUM0 = M * M * M;
    localparam longint NUM1 = 3 * J * J * J - 6 * J * J * D + 4 * D3;
    localparam longint NUM2 = -3 * J * J * J + 3 * J * J * D + 3 * J * D * D + D3;
    localparam longint NUM3 = J * J * J;
    localparam longint W0   = (NUM0 * WSCALE + 3 * D3) / DEN;
    localparam longint W1   = (NUM1 * WSCALE + 3 * D3) / DEN;
    localparam longint W2   = (NUM2 * WSCALE + 3 * D3) / DEN;
    localparam longint W3   = (NUM3 * WSCALE + 3 * D3) / DEN;
    assign wtab[j] = {WEIGHT_W'(W3), WEIGHT_W'(W2), WEIGHT_W'(W1), WEIGHT_W'(W0)};
  end

  assign weights = wtab[eval_idx];

endmodule

// File: rtl/core/bsc_eval.sv
// one coordinate of a curve point: four weighted products, registered, then
// rounded, summed and saturated; depends on bsc_pkg

module bsc_eval
  import bsc_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  weight_vec_t weights,
  input  coord_vec_t  pts,
  output coord_t      point
);

  localparam prod_t ROUND_BIAS = PROD_W'(1) << (WEIGHT_FRAC - 1);

  prod_t                     prod_r [NPTS];
  prod_t                     biased [NPTS];
  logic signed [TERM_W-1:0]  term   [NPTS];
  logic signed [SUM_W-1:0]   sum;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NPTS; k++) begin
        prod_r[k] <= $signed({1'b0, weights[k]}) * $signed(pts[k]);
      end
    end
  end

  // round to nearest, ties up, then exact sum
  always_comb begin
    sum = '0;
    for (int k = 0; k < NPTS; k++) begin
      biased[k] = prod_r[k] + ROUND_BIAS;
      term[k]   = biased[k][PROD_W-1:WEIGHT_FRAC];
      sum       = sum + SUM_W'(term[k]);
    end
    if ((&sum[SUM_W-1:COORD_W-1]) || (~|sum[SUM_W-1:COORD_W-1])) begin
      point = sum[COORD_W-1:0];
    end else if (sum[SUM_W-1]) begin
      point = COORD_MIN;
    end else begin
      point = COORD_MAX;
    end
  end

endmodule

// File: rtl/core/bspline_curve_subdivider.sv
// top level of the streaming uniform cubic b-spline subdivider
// depends on bsc_pkg, bsc_weight_rom and bsc_eval

// Control points (x, y) in signed q16.16 arrive one item at a time, sorted by
// x. The block keeps the three previous points; new_curve clears that history
// before its point is stored. Once four consecutive points are held, the
// newest point produces DIVISIONS line segments (DIVISIONS held to 1..64), one
// item each, segment j running from the curve value at t=j/DIVISIONS to
// t=(j+1)/DIVISIONS, with last_segment set on the final one. An item that
// yields segments occupies the block while its curve points are evaluated, one
// per cycle while the output is not stalled (x and y in parallel, four
// multipliers each); the first point only seeds the start of segment 0. The
// first segment follows its seed point through the window register, the
// product registers and the output register. The next item is taken in the
// cycle the last point of a run is evaluated, so back to back runs leave an
// empty output slot between them only for the seed point, and a stalled result
// does not hold off items that produce no segments while no run is in progress.

module bspline_curve_subdivider
  import bsc_pkg::*;
#(
  parameter int DIVISIONS = DIVISIONS_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  // control point input
  input  logic   in_valid,
  output logic   in_stall,
  input  coord_t in_point_x,
  input  coord_t in_point_y,
  input  logic   in_new_curve,
  // segment output
  output logic   out_valid,
  input  logic   out_stall,
  output coord_t out_x_start,
  output coord_t out_y_start,
  output coord_t out_x_end,
  output coord_t out_y_end,
  output logic   out_last_segment
);

  localparam int DIV_C = div_clamp(DIVISIONS);
  localparam int EW    = $clog2(DIV_C + 1);
  localparam logic [EW-1:0] E_LAST = EW'(DIV_C);

  // point history, index 0 oldest
  coord_t     hist_x_r [3];
  coord_t     hist_y_r [3];
  logic [1:0] held_r, held_nxt, held_base;

  // window under evaluation and its point counter
  coord_vec_t    win_x_r, win_y_r;
  logic          busy_r, busy_nxt;
  logic [EW-1:0] eval_r, eval_nxt;
  weight_vec_t   weights;

  // tags riding with the product registers
  logic   s1_valid_r, s1_first_r, s1_last_r;
  coord_t pt_x, pt_y;
  coord_t prev_x_r, prev_y_r;

  logic   out_valid_r, out_last_r;
  coord_t out_xs_r, out_ys_r, out_xe_r, out_ye_r;

  logic in_accept, adv, issue, eval_last, win_load;

  // whole evaluation pipe moves unless the output register is full and stalled
  assign adv       = !out_valid_r || !out_stall;
  assign eval_last = (eval_r == E_LAST);
  assign issue     = busy_r && adv;
  // free again once the final curve point of the run is issued
  assign in_stall  = busy_r && !(eval_last && adv);
  assign in_accept = in_valid && !in_stall;

  assign held_base = in_new_curve ? 2'd0 : held_r;
  assign win_load  = in_accept && (held_base == HELD_FULL);

  always_comb begin
    busy_nxt = busy_r;
    eval_nxt = eval_r;
    held_nxt = held_r;
    if (issue) begin
      if (eval_last) begin
        // park the counter on a valid table row
        busy_nxt = 1'b0;
        eval_nxt = '0;
      end else begin
        eval_nxt = eval_r + EW'(1);
      end
    end
    // a new window wins over the end of the previous run
    if (win_load) begin
      busy_nxt = 1'b1;
      eval_nxt = '0;
    end
    if (in_accept) begin
      held_nxt = (held_base == HELD_FULL) ? HELD_FULL : held_base + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      eval_r      <= '0;
      held_r      <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        hist_x_r[i] <= '0;
        hist_y_r[i] <= '0;
      end
    end else begin
      busy_r <= busy_nxt;
      eval_r <= eval_nxt;
      held_r <= held_nxt;
      if (adv) begin
        s1_valid_r  <= issue;
        // the first curve point of a run only becomes the next start
        out_valid_r <= s1_valid_r && !s1_first_r;
      end
      if (in_accept) begin
        // new_curve leaves only this point in the history
        hist_x_r[0] <= in_new_curve ? '0 : hist_x_r[1];
        hist_y_r[0] <= in_new_curve ? '0 : hist_y_r[1];
        hist_x_r[1] <= in_new_curve ? '0 : hist_x_r[2];
        hist_y_r[1] <= in_new_curve ? '0 : hist_y_r[2];
        hist_x_r[2] <= in_point_x;
        hist_y_r[2] <= in_point_y;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (win_load) begin
      win_x_r <= {in_point_x, hist_x_r[2], hist_x_r[1], hist_x_r[0]};
      win_y_r <= {in_point_y, hist_y_r[2], hist_y_r[1], hist_y_r[0]};
    end
    if (adv) begin
      s1_first_r <= (eval_r == '0);
      s1_last_r  <= eval_last;
      if (s1_valid_r) begin
        prev_x_r <= pt_x;
        prev_y_r <= pt_y;
        out_xs_r <= prev_x_r;
        out_ys_r <= prev_y_r;
        out_xe_r <= pt_x;
        out_ye_r <= pt_y;
        out_last_r <= s1_last_r;
      end
    end
  end

  bsc_weight_rom #(
    .DIVISIONS (DIVISIONS)
  ) u_rom (
    .eval_idx (eval_r),
    .weights  (weights)
  );

  bsc_eval u_eval_x (
    .clk     (clk),
    .en      (adv),
    .weights (weights),
    .pts     (win_x_r),
    .point   (pt_x)
  );

  bsc_eval u_eval_y (
    .clk     (clk),
    .en      (adv),
    .weights (weights),
    .pts     (win_y_r),
    .point   (pt_y)
  );

  assign out_valid        = out_valid_r;
  assign out_x_start      = out_xs_r;
  assign out_y_start      = out_ys_r;
  assign out_x_end        = out_xe_r;
  assign out_y_end        = out_ye_r;
  assign out_last_segment = out_last_r;

endmodule

// File: rtl/core/bsc_checker.sv
// port-level checks for the b-spline curve subdivider, bound to the top level
// depends on bsc_pkg

module bsc_checker
  import bsc_pkg::*;
(
  input logic   clk,
  input logic   rst_n,
  input logic   in_valid,
  input logic   in_stall,
  input coord_t in_point_x,
  input coord_t in_point_y,
  input logic   in_new_curve,
  input logic   out_valid,
  input logic   out_stall,
  input coord_t out_x_start,
  input coord_t out_y_start,
  input coord_t out_x_end,
  input coord_t out_y_end,
  input logic   out_last_segment
);

  // a stalled segment stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_x_start) &&
      $stable(out_y_start) && $stable(out_x_end) && $stable(out_y_end) &&
      $stable(out_last_segment))
    else $error("stalled segment changed");

  // a stalled control point stays put
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_point_x) &&
      $stable(in_point_y) && $stable(in_new_curve))
    else $error("stalled control point changed");

  // reset empties the pipe and frees the input
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

  // input stall only arises from an item taken just before
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(in_stall) |-> $past(in_valid))
    else $error("input stall without a preceding item");

endmodule

bind bspline_curve_subdivider bsc_checker u_chk (.*);
